[rtl/core/jts_pkg.sv]
// shared types and constants for the json token scanner
package jts_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [3:0] KIND_CURLY_OPEN  = 4'd0;
    localparam logic [3:0] KIND_CURLY_CLOSE = 4'd1;
    localparam logic [3:0] KIND_COLON       = 4'd2;
    localparam logic [3:0] KIND_COMMA       = 4'd3;
    localparam logic [3:0] KIND_ARRAY_OPEN  = 4'd4;
    localparam logic [3:0] KIND_ARRAY_CLOSE = 4'd5;
    localparam logic [3:0] KIND_STRING      = 4'd6;
    localparam logic [3:0] KIND_NUMBER      = 4'd7;
    localparam logic [3:0] KIND_BOOLEAN     = 4'd8;
    localparam logic [3:0] KIND_NULL        = 4'd9;
    localparam logic [3:0] KIND_UNKNOWN     = 4'd10;
    localparam logic [3:0] KIND_UNTERM      = 4'd11;

    localparam logic [7:0] CHAR_CURLY_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_CURLY_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_ARRAY_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_ARRAY_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_COLON       = 8'h3A;
    localparam logic [7:0] CHAR_COMMA       = 8'h2C;
    localparam logic [7:0] CHAR_MINUS       = 8'h2D;
    localparam logic [7:0] CHAR_DOT         = 8'h2E;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;
    localparam logic [7:0] CHAR_QUOTE       = 8'h22;
    localparam logic [7:0] CHAR_ZERO        = 8'h30;
    localparam logic [7:0] CHAR_NINE        = 8'h39;
    localparam logic [7:0] CHAR_T           = 8'h74;
    localparam logic [7:0] CHAR_F           = 8'h66;
    localparam logic [7:0] CHAR_N           = 8'h6E;

    localparam logic [2:0] SKIP_FALSE = 3'd4;
    localparam logic [2:0] SKIP_OTHER = 3'd3;

    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] char_value;
        logic       has_char;
        logic       token_done;
        logic       bool_value;
    } tok_t;

    // up to three results caused by one byte, count is 1 to 3
    typedef struct packed {
        tok_t [2:0] toks;
        logic [1:0] count;
    } entry_t;

    function automatic tok_t make_tok(input logic [3:0] kind, input logic [7:0] ch,
                                      input logic has, input logic done,
                                      input logic bv);
        tok_t t;
        t.token_kind = kind;
        t.char_value = has ? ch : 8'd0;
        t.has_char   = has;
        t.token_done = done;
        t.bool_value = bv;
        return t;
    endfunction

endpackage

[rtl/core/jts_front.sv]
// front end: byte classification, scan state and result list per byte
module jts_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [7:0]      text_byte,
    input  logic            last_byte,
    input  logic            push,
    input  logic            full,
    output logic            q_write,
    output jts_pkg::entry_t q_entry
);
    import jts_pkg::*;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_STRING = 2'd1;
    localparam logic [1:0] MODE_NUMBER = 2'd2;
    localparam logic [1:0] MODE_SKIP   = 2'd3;

    typedef struct packed {
        tok_t       t0;
        tok_t       t1;
        logic [1:0] n;
        logic [1:0] mode;
        logic [2:0] skip;
    } idle_res_t;

    function automatic idle_res_t scan_idle(input logic [7:0] c, input logic last,
                                            input logic [2:0] skip);
        idle_res_t r;
        r.t0   = '0;
        r.t1   = '0;
        r.n    = 2'd0;
        r.mode = MODE_IDLE;
        r.skip = skip;
        case (c)
            CHAR_SPACE, CHAR_NEWLINE:
            begin
                r.n = 2'd0;
            end
            CHAR_QUOTE:
            begin
                if (last)
                begin
                    r.t0 = make_tok(KIND_UNTERM, 8'd0, 1'b0, 1'b1, 1'b0);
                    r.n  = 2'd1;
                end
                else
                begin
                    r.mode = MODE_STRING;
                end
            end
            CHAR_CURLY_OPEN:
            begin
                r.t0 = make_tok(KIND_CURLY_OPEN, 8'd0, 1'b0, 1'b1, 1'b0);
                r.n  = 2'd1;
            end
            CHAR_CURLY_CLOSE:
            begin
                r.t0 = make_tok(KIND_CURLY_CLOSE, 8'd0, 1'b0, 1'b1, 1'b0);
                r.n  = 2'd1;
            end
            CHAR_ARRAY_OPEN:
            begin
                r.t0 = make_tok(KIND_ARRAY_OPEN, 8'd0, 1'b0, 1'b1, 1'b0);
                r.n  = 2'd1;
            end
            CHAR_ARRAY_CLOSE:
            begin
                r.t0 = make_tok(KIND_ARRAY_CLOSE, 8'd0, 1'b0, 1'b1, 1'b0);
                r.n  = 2'd1;
            end
            CHAR_COLON:
            begin
                r.t0 = make_tok(KIND_COLON, 8'd0, 1'b0, 1'b1, 1'b0);
                r.n  = 2'd1;
            end
            CHAR_COMMA:
            begin
                r.t0 = make_tok(KIND_COMMA, 8'd0, 1'b0, 1'b1, 1'b0);
                r.n  = 2'd1;
            end
            CHAR_T, CHAR_F, CHAR_N:
            begin
                if (c == CHAR_N)
                    r.t0 = make_tok(KIND_NULL, 8'd0, 1'b0, 1'b1, 1'b0);
                else
                    r.t0 = make_tok(KIND_BOOLEAN, 8'd0, 1'b0, 1'b1, c == CHAR_T);
                if (last)
                begin
                    r.t1 = make_tok(KIND_UNTERM, 8'd0, 1'b0, 1'b1, 1'b0);
                    r.n  = 2'd2;
                end
                else
                begin
                    r.n    = 2'd1;
                    r.mode = MODE_SKIP;
                    r.skip = (c == CHAR_F) ? SKIP_FALSE : SKIP_OTHER;
                end
            end
            default:
            begin
                r.n = 2'd1;
                if (c == CHAR_MINUS || (c inside {[CHAR_ZERO:CHAR_NINE]}))
                begin
                    r.t0 = make_tok(KIND_NUMBER, c, 1'b1, last, 1'b0);
                    if (!last)
                        r.mode = MODE_NUMBER;
                end
                else
                begin
                    r.t0 = make_tok(KIND_UNKNOWN, 8'd0, 1'b0, 1'b1, 1'b0);
                end
            end
        endcase
        return r;
    endfunction

    logic [1:0] mode_reg, mode_next;
    logic [2:0] skip_reg, skip_next;
    logic [1:0] eff_mode;
    logic [2:0] skip_dec;
    logic       num_char;
    logic       accept;
    idle_res_t  res;
    tok_t [2:0] toks;
    logic [1:0] n;

    assign accept   = push && !full;
    assign eff_mode = (mode_reg == MODE_SKIP && skip_reg == 3'd0) ? MODE_IDLE : mode_reg;
    assign skip_dec = skip_reg - 3'd1;
    assign num_char = (text_byte == CHAR_MINUS) || (text_byte == CHAR_DOT) ||
                      (text_byte inside {[CHAR_ZERO:CHAR_NINE]});
    assign res      = scan_idle(text_byte, last_byte, skip_reg);

    always_comb
    begin
        toks      = '0;
        n         = 2'd0;
        mode_next = MODE_IDLE;
        skip_next = skip_reg;
        case (eff_mode)
            MODE_STRING:
            begin
                if (text_byte == CHAR_QUOTE)
                begin
                    toks[0] = make_tok(KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0);
                    n       = 2'd1;
                end
                else
                begin
                    toks[0] = make_tok(KIND_STRING, text_byte, 1'b1, 1'b0, 1'b0);
                    if (last_byte)
                    begin
                        toks[1] = make_tok(KIND_UNTERM, 8'd0, 1'b0, 1'b1, 1'b0);
                        n       = 2'd2;
                    end
                    else
                    begin
                        n         = 2'd1;
                        mode_next = MODE_STRING;
                    end
                end
            end
            MODE_NUMBER:
            begin
                if (num_char)
                begin
                    toks[0] = make_tok(KIND_NUMBER, text_byte, 1'b1, last_byte, 1'b0);
                    n       = 2'd1;
                    if (!last_byte)
                        mode_next = MODE_NUMBER;
                end
                else
                begin
                    // close the number, then scan the byte as a new token
                    toks[0]   = make_tok(KIND_NUMBER, 8'd0, 1'b0, 1'b1, 1'b0);
                    toks[1]   = res.t0;
                    toks[2]   = res.t1;
                    n         = res.n + 2'd1;
                    mode_next = res.mode;
                    skip_next = res.skip;
                end
            end
            MODE_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec != 3'd0)
                begin
                    if (last_byte)
                    begin
                        toks[0] = make_tok(KIND_UNTERM, 8'd0, 1'b0, 1'b1, 1'b0);
                        n       = 2'd1;
                    end
                    else
                    begin
                        mode_next = MODE_SKIP;
                    end
                end
            end
            default:
            begin
                toks[0]   = res.t0;
                toks[1]   = res.t1;
                n         = res.n;
                mode_next = res.mode;
                skip_next = res.skip;
            end
        endcase
        if (last_byte)
        begin
            mode_next = MODE_IDLE;
            skip_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            skip_reg <= 3'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            skip_reg <= skip_next;
        end
    end

    assign q_write       = accept && (n != 2'd0);
    assign q_entry.toks  = toks;
    assign q_entry.count = n;

endmodule

[rtl/core/jts_queue.sv]
// short queue of result groups between front and back end
module jts_queue #(
    parameter int unsigned DEPTH = jts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  jts_pkg::entry_t wr_entry,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output jts_pkg::entry_t rd_entry
);
    import jts_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    entry_t        entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = entries_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entries_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

[rtl/core/jts_back.sv]
// back end: expands result groups into single results behind an output register
module jts_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  jts_pkg::entry_t q_entry,
    output logic            q_read,
    input  logic            pop,
    output logic            empty,
    output logic [3:0]      token_kind,
    output logic [7:0]      char_value,
    output logic            has_char,
    output logic            token_done,
    output logic            bool_value,
    output logic            last_result
);
    import jts_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [1:0] idx_reg, idx_next;
    tok_t       tok_reg;
    logic       last_reg;
    tok_t       sel_tok;
    logic       sel_last;
    logic       load;

    assign load     = q_valid && (!out_valid_reg || pop);
    assign sel_last = (idx_reg == q_entry.count - 2'd1);
    assign q_read   = load && sel_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_tok = q_entry.toks[0];
            2'd1:    sel_tok = q_entry.toks[1];
            default: sel_tok = q_entry.toks[2];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = sel_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= sel_tok;
            last_reg <= sel_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign token_kind  = tok_reg.token_kind;
    assign char_value  = tok_reg.char_value;
    assign has_char    = tok_reg.has_char;
    assign token_done  = tok_reg.token_done;
    assign bool_value  = tok_reg.bool_value;
    assign last_result = last_reg;

endmodule

[rtl/core/json_token_scanner.sv]
// top level of the json token scanner
//
//  channel  | transfer when       | payload
//  ---------+---------------------+------------------------------------------------
//  input    | push && !full       | text_byte, last_byte
//  result   | pop && !empty       | token_kind, char_value, has_char, token_done,
//           |                     | bool_value, last_result
//
// one byte per cycle enters the front end while full is low and turns into a group of
// 0 to 3 results; the back end hands out one result per cycle while pop is high;
// results pass the group queue and output register; full rises when the queue is full
// reset clears scan state and empties queue and output register; no clearing pass
module json_token_scanner #(
    parameter int unsigned QUEUE_DEPTH = jts_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    input  logic       push,
    output logic       full,
    output logic [3:0] token_kind,
    output logic [7:0] char_value,
    output logic       has_char,
    output logic       token_done,
    output logic       bool_value,
    output logic       last_result,
    output logic       empty,
    input  logic       pop
);
    import jts_pkg::*;

    logic   q_write;
    entry_t q_wr_entry;
    logic   q_read;
    logic   q_valid;
    entry_t q_rd_entry;

    jts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_byte (text_byte),
        .last_byte (last_byte),
        .push      (push),
        .full      (full),
        .q_write   (q_write),
        .q_entry   (q_wr_entry)
    );

    jts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_write),
        .wr_entry (q_wr_entry),
        .full     (full),
        .rd_en    (q_read),
        .rd_valid (q_valid),
        .rd_entry (q_rd_entry)
    );

    jts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_rd_entry),
        .q_read      (q_read),
        .pop         (pop),
        .empty       (empty),
        .token_kind  (token_kind),
        .char_value  (char_value),
        .has_char    (has_char),
        .token_done  (token_done),
        .bool_value  (bool_value),
        .last_result (last_result)
    );

endmodule

[tb/sv/json_token_scanner_test.sv]
// self-checking testbench for the json token scanner with a scoreboard class and random texts
`timescale 1ns / 100ps

module json_token_scanner_test;

    import jts_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 360;
    localparam logic [7:0] PUNCT_BYTES [6] = '{CHAR_CURLY_OPEN, CHAR_CURLY_CLOSE,
        CHAR_ARRAY_OPEN, CHAR_ARRAY_CLOSE, CHAR_COLON, CHAR_COMMA};

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_STRING, SCAN_NUMBER, SCAN_SKIP} scan_mode_t;

    typedef struct packed {
        tok_t tok;
        logic last_result;
    } token_rec_t;

    class token_scoreboard;
        token_rec_t expected_tokens[$];
        token_rec_t byte_tokens[$];
        scan_mode_t mode;
        logic [2:0] skip_count;
        int failures;

        function new();
            mode = SCAN_IDLE;
            skip_count = 3'd0;
            failures = 0;
        endfunction

        function void add_token(logic [3:0] kind, logic [7:0] ch, logic has, logic done,
                                logic bv);
            token_rec_t r;
            r.tok.token_kind = kind;
            r.tok.char_value = has ? ch : 8'd0;
            r.tok.has_char = has;
            r.tok.token_done = done;
            r.tok.bool_value = bv;
            r.last_result = 1'b0;
            byte_tokens.push_back(r);
        endfunction

        // a byte seen between tokens
        function void open_token(logic [7:0] c, logic l);
            case (c)
                CHAR_SPACE, CHAR_NEWLINE: ;
                CHAR_QUOTE:
                begin
                    if (l)
                        add_token(KIND_UNTERM, 8'd0, 1'b0, 1'b1, 1'b0);
                    else
                        mode = SCAN_STRING;
                end
                CHAR_CURLY_OPEN:  add_token(KIND_CURLY_OPEN, 8'd0, 1'b0, 1'b1, 1'b0);
                CHAR_CURLY_CLOSE: add_token(KIND_CURLY_CLOSE, 8'd0, 1'b0, 1'b1, 1'b0);
                CHAR_ARRAY_OPEN:  add_token(KIND_ARRAY_OPEN, 8'd0, 1'b0, 1'b1, 1'b0);
                CHAR_ARRAY_CLOSE: add_token(KIND_ARRAY_CLOSE, 8'd0, 1'b0, 1'b1, 1'b0);
                CHAR_COLON:       add_token(KIND_COLON, 8'd0, 1'b0, 1'b1, 1'b0);
                CHAR_COMMA:       add_token(KIND_COMMA, 8'd0, 1'b0, 1'b1, 1'b0);
                CHAR_T, CHAR_F, CHAR_N:
                begin
                    if (c == CHAR_N)
                        add_token(KIND_NULL, 8'd0, 1'b0, 1'b1, 1'b0);
                    else
                        add_token(KIND_BOOLEAN, 8'd0, 1'b0, 1'b1, c == CHAR_T);
                    if (l)
                    begin
                        add_token(KIND_UNTERM, 8'd0, 1'b0, 1'b1, 1'b0);
                    end
                    else
                    begin
                        mode = SCAN_SKIP;
                        skip_count = (c == CHAR_F) ? SKIP_FALSE : SKIP_OTHER;
                    end
                end
                default:
                begin
                    if (c == CHAR_MINUS || (c >= CHAR_ZERO && c <= CHAR_NINE))
                    begin
                        add_token(KIND_NUMBER, c, 1'b1, l, 1'b0);
                        if (!l)
                            mode = SCAN_NUMBER;
                    end
                    else
                    begin
                        add_token(KIND_UNKNOWN, 8'd0, 1'b0, 1'b1, 1'b0);
                    end
                end
            endcase
        endfunction

        // accepted input transfer, returns the number of results it causes
        function int scan_byte(logic [7:0] c, logic l);
            scan_mode_t m;
            token_rec_t r;
            int n;
            m = mode;
            if (m == SCAN_SKIP && skip_count == 3'd0)
                m = SCAN_IDLE;
            mode = SCAN_IDLE;
            byte_tokens.delete();
            case (m)
                SCAN_STRING:
                begin
                    if (c == CHAR_QUOTE)
                    begin
                        add_token(KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0);
                    end
                    else
                    begin
                        add_token(KIND_STRING, c, 1'b1, 1'b0, 1'b0);
                        if (l)
                            add_token(KIND_UNTERM, 8'd0, 1'b0, 1'b1, 1'b0);
                        else
                            mode = SCAN_STRING;
                    end
                end
                SCAN_NUMBER:
                begin
                    if (c == CHAR_MINUS || c == CHAR_DOT ||
                        (c >= CHAR_ZERO && c <= CHAR_NINE))
                    begin
                        add_token(KIND_NUMBER, c, 1'b1, l, 1'b0);
                        if (!l)
                            mode = SCAN_NUMBER;
                    end
                    else
                    begin
                        add_token(KIND_NUMBER, 8'd0, 1'b0, 1'b1, 1'b0);
                        open_token(c, l);
                    end
                end
                SCAN_SKIP:
                begin
                    skip_count = skip_count - 3'd1;
                    if (skip_count != 3'd0)
                    begin
                        if (l)
                            add_token(KIND_UNTERM, 8'd0, 1'b0, 1'b1, 1'b0);
                        else
                            mode = SCAN_SKIP;
                    end
                end
                default: open_token(c, l);
            endcase
            if (l)
            begin
                mode = SCAN_IDLE;
                skip_count = 3'd0;
            end
            n = byte_tokens.size();
            for (int i = 0; i < n; i++)
            begin
                r = byte_tokens[i];
                r.last_result = (i == n - 1);
                expected_tokens.push_back(r);
            end
            return n;
        endfunction

        // accepted result transfer
        function void match_token(token_rec_t seen);
            token_rec_t want;
            if (expected_tokens.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected: kind %0d char %02h has %0b done %0b bool %0b last %0b",
                             seen.tok.token_kind, seen.tok.char_value, seen.tok.has_char,
                             seen.tok.token_done, seen.tok.bool_value, seen.last_result);
                return;
            end
            want = expected_tokens.pop_front();
            if (seen.tok.token_kind !== want.tok.token_kind ||
                seen.tok.char_value !== want.tok.char_value ||
                seen.tok.has_char !== want.tok.has_char ||
                seen.tok.token_done !== want.tok.token_done ||
                seen.tok.bool_value !== want.tok.bool_value ||
                seen.last_result !== want.last_result)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("expected: kind %0d char %02h has %0b done %0b bool %0b last %0b",
                             want.tok.token_kind, want.tok.char_value, want.tok.has_char,
                             want.tok.token_done, want.tok.bool_value, want.last_result);
                    $display("actual:   kind %0d char %02h has %0b done %0b bool %0b last %0b",
                             seen.tok.token_kind, seen.tok.char_value, seen.tok.has_char,
                             seen.tok.token_done, seen.tok.bool_value, seen.last_result);
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic [7:0] text_byte;
    logic       last_byte;
    logic       push;
    logic       full;
    logic [3:0] token_kind;
    logic [7:0] char_value;
    logic       has_char;
    logic       token_done;
    logic       bool_value;
    logic       last_result;
    logic       empty;
    logic       pop;

    token_scoreboard board = new();
    logic [7:0] text_q[$];
    bit idle_on;
    int sent_bytes;
    int cycle_count;

    json_token_scanner DUT (
        .clk(clk),
        .rst_n(rst_n),
        .text_byte(text_byte),
        .last_byte(last_byte),
        .push(push),
        .full(full),
        .token_kind(token_kind),
        .char_value(char_value),
        .has_char(has_char),
        .token_done(token_done),
        .bool_value(bool_value),
        .last_result(last_result),
        .empty(empty),
        .pop(pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic l);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 7);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        text_byte <= c;
        last_byte <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        void'(board.scan_byte(c, l));
        sent_bytes++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    // hold the sender until every expected result has come out
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (board.expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] num_byte();
        int r;
        r = $urandom_range(0, 11);
        if (r == 10)
            return CHAR_MINUS;
        if (r == 11)
            return CHAR_DOT;
        return 8'(CHAR_ZERO + r);
    endfunction

    function automatic void add_random_token();
        string words[3];
        logic [7:0] c;
        int pick;
        int len;
        words = '{"true", "false", "null"};
        pick = $urandom_range(0, 11);
        case (pick)
            0, 1: text_q.push_back(PUNCT_BYTES[$urandom_range(0, 5)]);
            2, 3:
            begin
                text_q.push_back(CHAR_QUOTE);
                len = $urandom_range(0, 4);
                repeat (len)
                begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CHAR_QUOTE)
                        c = 8'hA2;
                    text_q.push_back(c);
                end
                text_q.push_back(CHAR_QUOTE);
            end
            4, 5:
            begin
                text_q.push_back($urandom_range(0, 3) == 0 ? CHAR_MINUS
                                 : 8'(CHAR_ZERO + $urandom_range(0, 9)));
                len = $urandom_range(0, 4);
                repeat (len)
                    text_q.push_back(num_byte());
            end
            6, 7, 8:
            begin
                for (int i = 0; i < words[pick - 6].len(); i++)
                    text_q.push_back(words[pick - 6][i]);
            end
            9:
            begin
                case ($urandom_range(0, 2))
                    0: text_q.push_back(CHAR_T);
                    1: text_q.push_back(CHAR_F);
                    default: text_q.push_back(CHAR_N);
                endcase
                repeat (4)
                    text_q.push_back(8'($urandom_range(0, 255)));
            end
            10: text_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE);
            default: text_q.push_back(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 1) == 0)
            text_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE);
    endfunction

    // receiver with random stall bursts
    initial
    begin
        int stall_left;
        token_rec_t seen;
        stall_left = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                seen.tok.token_kind = token_kind;
                seen.tok.char_value = char_value;
                seen.tok.has_char = has_char;
                seen.tok.token_done = token_done;
                seen.tok.bool_value = bool_value;
                seen.last_result = last_result;
                board.match_token(seen);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin
        int cut;
        bit paused;
        cycle_count = 0;
        sent_bytes = 0;
        idle_on = 1'b1;
        paused = 1'b0;
        rst_n <= 1'b0;
        push <= 1'b0;
        text_byte <= 8'd0;
        last_byte <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // punctuation, strings, number closed by a token byte, lone dot, extreme bytes,
        // boolean skip, null cut short by the end of text
        text_q = '{CHAR_CURLY_OPEN, CHAR_QUOTE, 8'h61, CHAR_QUOTE, CHAR_COLON,
                   CHAR_ARRAY_OPEN, CHAR_MINUS, CHAR_ZERO + 8'd1, CHAR_DOT,
                   CHAR_ZERO + 8'd5, CHAR_ARRAY_CLOSE, CHAR_COMMA, CHAR_QUOTE,
                   CHAR_QUOTE, CHAR_SPACE, CHAR_NEWLINE, CHAR_DOT, 8'hFF, 8'h00,
                   CHAR_CURLY_CLOSE, CHAR_T, 8'h72, 8'h75, 8'h65, CHAR_N, 8'h75};
        send_text();
        // number running into the end of text
        text_q = '{CHAR_MINUS, CHAR_NINE};
        send_text();
        // quote as the last byte
        text_q = '{CHAR_QUOTE};
        send_text();
        wait_drained();

        sent_bytes = 0;
        while (sent_bytes < RANDOM_BYTES)
        begin
            text_q.delete();
            repeat ($urandom_range(1, 8))
                add_random_token();
            if ($urandom_range(0, 3) == 0)
            begin
                cut = $urandom_range(1, text_q.size());
                while (text_q.size() > cut)
                    void'(text_q.pop_back());
            end
            if (sent_bytes > RANDOM_BYTES * 4 / 5)
                idle_on = 1'b0;
            send_text();
            if (!paused && sent_bytes >= RANDOM_BYTES / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (board.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/core/jts_pkg.sv
rtl/core/jts_front.sv
rtl/core/jts_queue.sv
rtl/core/jts_back.sv
rtl/core/json_token_scanner.sv
tb/sv/json_token_scanner_test.sv
